/* rtl/lmp_pkg.sv */
// Shared types, constants and functions for the LED matrix PWM refresh block.
// Holds the gamma table builder, the chain remap and the controller/datapath
// command and status structs. No dependencies.
`default_nettype none

package lmp_pkg;

	// Geometry of the pixel stores: 256 pixels kept as 32 rows of 8 lanes.
	localparam int GRAY_BITS = 7;
	localparam int NUM_PIX   = 256;
	localparam int LANES     = 8;
	localparam int ROWS      = NUM_PIX / LANES;
	localparam int ROW_W     = $clog2(ROWS);
	localparam int LANE_W    = $clog2(LANES);
	localparam int ROW_BITS  = LANES * GRAY_BITS;
	localparam int FULL_LVL  = (1 << GRAY_BITS) - 1;

	// Operation codes of the input item.
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_SHOW  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	typedef logic [GRAY_BITS-1:0] level_t;
	typedef logic [ROW_BITS-1:0]  row_t;
	typedef logic [255:0][GRAY_BITS-1:0] gamma_lut_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic addr_clear;
		logic addr_step;
		logic load_pixel;
		logic pix_write;
		logic copy_row;
		logic set_shown;
		logic phase_step;
		logic emit;
	} lmp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pix_ok;
		logic blank;
		logic addr_last;
		logic out_room;
	} lmp_stat_t;

	// Builds the gamma table at elaboration. A level n fits a grey value g when
	// n^10 * 256^27 <= g^27 * FULL^10, which is exact integer arithmetic for the
	// 2.7 exponent. The entry is one plus the largest fitting n below FULL.
	function automatic gamma_lut_t build_gamma();
		gamma_lut_t    lut;
		logic [319:0]  lhs;
		logic [319:0]  rhs;
		logic [319:0]  big_n;
		logic [319:0]  big_g;
		int unsigned   lo;
		int unsigned   hi;
		int unsigned   mid;
		int            g;
		int            it;
		int            i;
		for (g = 0; g < 256; g++) begin
			lut[g] = '0;
			if (g != 0) begin
				lo = 0;
				hi = FULL_LVL - 1;
				for (it = 0; it <= GRAY_BITS; it++) begin
					if (lo < hi) begin
						mid   = (lo + hi + 1) >> 1;
						big_n = 320'(mid);
						big_g = 320'(g);
						lhs   = 320'(1);
						rhs   = 320'(1);
						for (i = 0; i < 10; i++) begin
							lhs = lhs * big_n;
							rhs = rhs * 320'(FULL_LVL);
						end
						lhs = lhs << 216;
						for (i = 0; i < 27; i++) begin
							rhs = rhs * big_g;
						end
						if (lhs <= rhs) begin
							lo = mid;
						end else begin
							hi = mid - 1;
						end
					end
				end
				lut[g] = GRAY_BITS'(lo + 1);
			end
		end
		return lut;
	endfunction

	localparam gamma_lut_t GAMMA_LUT = build_gamma();

	// Maps a raster position to its place on the shift chain. Each block of
	// 64 pixels is split into eight segments of eight that snake through it.
	function automatic logic [7:0] remap_pos(input logic [7:0] p);
		logic [2:0] k;
		logic [5:0] kx;
		logic [5:0] ofs;
		k  = p[2:0];
		kx = {3'b000, k};
		case (p[5:3])
			3'd0:    ofs = kx;
			3'd1:    ofs = 6'd16 + kx;
			3'd2:    ofs = 6'd15 - kx;
			3'd3:    ofs = 6'd31 - kx;
			3'd4:    ofs = 6'd48 + kx;
			3'd5:    ofs = 6'd32 + kx;
			3'd6:    ofs = 6'd63 - kx;
			default: ofs = 6'd47 - kx;
		endcase
		return {p[7:6], ofs};
	endfunction

endpackage

`default_nettype wire

/* rtl/lmp_ctrl.sv */
// Controller state machine of the LED matrix PWM refresh block.
// Sequences pixel writes, front-to-back copies and frame transmission.
// Depends on lmp_pkg.
`default_nettype none

module lmp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire logic [1:0]        operation,
	input  wire lmp_pkg::lmp_stat_t stat,
	output lmp_pkg::lmp_cmd_t      cmd
);
	import lmp_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WRITE = 2'd1;
	localparam logic [1:0] ST_COPY  = 2'd2;
	localparam logic [1:0] ST_SEND  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       item_fire;

	// New items are taken only between operations.
	assign item_stall = (state_q != ST_IDLE);
	assign item_fire  = item_valid && !item_stall;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (item_fire) begin
					case (operation)
						OP_WRITE: begin
							if (stat.pix_ok) begin
								cmd.load_pixel = 1'b1;
								state_d        = ST_WRITE;
							end
						end
						OP_SHOW: begin
							cmd.addr_clear = 1'b1;
							state_d        = ST_COPY;
						end
						OP_TICK: begin
							if (!stat.blank) begin
								cmd.addr_clear = 1'b1;
								cmd.phase_step = 1'b1;
								state_d        = ST_SEND;
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_WRITE: begin
				cmd.pix_write = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_COPY: begin
				cmd.copy_row  = 1'b1;
				cmd.addr_step = 1'b1;
				if (stat.addr_last) begin
					cmd.set_shown = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_SEND: begin
				if (stat.out_room) begin
					cmd.emit      = 1'b1;
					cmd.addr_step = 1'b1;
					if (stat.addr_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/lmp_datapath.sv */
// Datapath of the LED matrix PWM refresh block: pixel intake with gamma and
// remap, the front and back row stores, the PWM phase and the output register.
// Depends on lmp_pkg.
`default_nettype none

module lmp_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lmp_pkg::lmp_cmd_t  cmd,
	output lmp_pkg::lmp_stat_t      stat,
	input  wire logic signed [15:0] x_coord,
	input  wire logic signed [15:0] y_coord,
	input  wire logic [15:0]        gray_level,
	output logic                    byte_valid,
	input  wire logic               byte_stall,
	output logic [7:0]              shift_bits,
	output logic                    last
);
	import lmp_pkg::*;

	// Row stores: one row holds eight pixels, lane j at bits j*GRAY_BITS.
	row_t front_mem [ROWS];
	row_t back_mem  [ROWS];

	logic [ROWS-1:0]   row_valid_q;
	logic [ROW_W-1:0]  addr_q;
	logic [ROW_W-1:0]  addr_d;
	row_t              front_rd_q;
	row_t              back_rd_q;
	row_t              front_row;
	row_t              merged_row;

	logic [LANE_W-1:0] pix_lane_q;
	level_t            pix_val_q;
	logic [7:0]        gray_sat;
	logic [7:0]        chain_pos;

	level_t            phase_q;
	logic              blank_q;
	logic              out_valid_q;
	logic [7:0]        shift_bits_q;
	logic              last_q;
	logic [7:0]        lit_bits;

	// Pixel intake: range check, saturation, gamma and chain position.
	assign gray_sat  = (gray_level[15:8] != 8'd0) ? 8'hFF : gray_level[7:0];
	assign chain_pos = remap_pos({y_coord[3:0], x_coord[3:0]});

	always_ff @(posedge clk) begin
		if (cmd.load_pixel) begin
			pix_lane_q <= chain_pos[LANE_W-1:0];
			pix_val_q  <= GAMMA_LUT[gray_sat];
		end
	end

	// Shared row address; both stores are read at the next address every cycle.
	always_comb begin
		if (cmd.addr_clear) begin
			addr_d = '0;
		end else if (cmd.load_pixel) begin
			addr_d = chain_pos[7:LANE_W];
		end else if (cmd.addr_step) begin
			addr_d = addr_q + ROW_W'(1);
		end else begin
			addr_d = addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else begin
			addr_q <= addr_d;
		end
	end

	// A front row never written reads as all zero.
	assign front_row = row_valid_q[addr_q] ? front_rd_q : '0;

	// Read-modify-write merge of one pixel into its row.
	always_comb begin
		merged_row = front_row;
		for (int j = 0; j < LANES; j++) begin
			if (pix_lane_q == LANE_W'(j)) begin
				merged_row[j*GRAY_BITS +: GRAY_BITS] = pix_val_q;
			end
		end
	end

	// Front store.
	always_ff @(posedge clk) begin
		if (cmd.pix_write) begin
			front_mem[addr_q] <= merged_row;
		end
		front_rd_q <= front_mem[addr_d];
	end

	// Back store, filled only by the copy sweep.
	always_ff @(posedge clk) begin
		if (cmd.copy_row) begin
			back_mem[addr_q] <= front_row;
		end
		back_rd_q <= back_mem[addr_d];
	end

	// Row valid flags, PWM phase and blanking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			phase_q     <= '0;
			blank_q     <= 1'b1;
		end else begin
			if (cmd.pix_write) begin
				row_valid_q[addr_q] <= 1'b1;
			end
			if (cmd.phase_step) begin
				phase_q <= phase_q + GRAY_BITS'(1);
			end
			if (cmd.set_shown) begin
				blank_q <= 1'b0;
			end
		end
	end

	// A pixel is lit while its level exceeds the phase.
	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			lit_bits[j] = (back_rd_q[j*GRAY_BITS +: GRAY_BITS] > phase_q);
		end
	end

	// Output register; it holds a byte while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!byte_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			shift_bits_q <= lit_bits;
			last_q       <= (addr_q == ROW_W'(ROWS - 1));
		end
	end

	assign byte_valid = out_valid_q;
	assign shift_bits = shift_bits_q;
	assign last       = last_q;

	// Status to the controller.
	assign stat.pix_ok    = (x_coord[15:4] == 12'd0) && (y_coord[15:4] == 12'd0);
	assign stat.blank     = blank_q;
	assign stat.addr_last = (addr_q == ROW_W'(ROWS - 1));
	assign stat.out_room  = !out_valid_q || !byte_stall;

endmodule

`default_nettype wire

/* rtl/led_matrix_pwm_refresh.sv */
// Top level of the LED matrix PWM refresh block: controller and datapath.
// Depends on lmp_pkg, lmp_ctrl and lmp_datapath.
//
//   Channel  Handshake              Payload
//   item     item_valid/item_stall  operation, x_coord, y_coord, gray_level
//   byte     byte_valid/byte_stall  shift_bits, last
//
// A pixel write is accepted, then a read-modify-write of its row follows.
// A show copies the 32 front rows to the back store.
// A tick streams one byte a cycle from the back store's read port while the
// byte channel does not stall. Dropped items are accepted and discarded.
// Reset clears row valid flags, so no clearing pass follows it.
`default_nettype none

module led_matrix_pwm_refresh (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic [1:0]         operation,
	input  wire logic signed [15:0] x_coord,
	input  wire logic signed [15:0] y_coord,
	input  wire logic [15:0]        gray_level,
	output logic                    byte_valid,
	input  wire logic               byte_stall,
	output logic [7:0]              shift_bits,
	output logic                    last
);
	import lmp_pkg::*;

	lmp_cmd_t  cmd;
	lmp_stat_t stat;

	lmp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.operation  (operation),
		.stat       (stat),
		.cmd        (cmd)
	);

	lmp_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.x_coord    (x_coord),
		.y_coord    (y_coord),
		.gray_level (gray_level),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.shift_bits (shift_bits),
		.last       (last)
	);

endmodule

`default_nettype wire

/* rtl/lmp_checker.sv */
// Port-level checks for the LED matrix PWM refresh block, bound to the top.
// Depends on lmp_pkg.
`default_nettype none

module lmp_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               item_valid,
	input wire logic               item_stall,
	input wire logic [1:0]         operation,
	input wire logic signed [15:0] x_coord,
	input wire logic signed [15:0] y_coord,
	input wire logic               byte_valid,
	input wire logic               byte_stall,
	input wire logic [7:0]         shift_bits,
	input wire logic               last
);
	import lmp_pkg::*;

	logic item_xfer;
	logic pix_in_range;

	assign item_xfer    = item_valid && !item_stall;
	assign pix_in_range = (x_coord[15:4] == 12'd0) && (y_coord[15:4] == 12'd0);

	// A stalled byte holds its payload.
	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(shift_bits) && $stable(last))
		else $error("byte payload changed while stalled");

	// An in-range write holds off the next item while its row is updated.
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_xfer && operation == OP_WRITE && pix_in_range |=> item_stall)
		else $error("pixel write did not hold off the next item");

	// A show is busy for exactly the 32-row copy.
	a_show_len: assert property (@(posedge clk) disable iff (!arst_n)
		item_xfer && operation == OP_SHOW |-> ##32 item_stall ##1 !item_stall)
		else $error("show copy length wrong");

	// The byte after a frame's last transfer never closes a frame.
	a_last_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_stall && last |=> !(byte_valid && last))
		else $error("two frame ends back to back");

endmodule

bind led_matrix_pwm_refresh lmp_checker u_lmp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item_valid),
	.item_stall (item_stall),
	.operation  (operation),
	.x_coord    (x_coord),
	.y_coord    (y_coord),
	.byte_valid (byte_valid),
	.byte_stall (byte_stall),
	.shift_bits (shift_bits),
	.last       (last)
);

`default_nettype wire
